[hw/rtl/priority_queue_linear_scan_defines.svh]
// Assertion macros shared by the priority queue checker.
`ifndef PRIORITY_QUEUE_LINEAR_SCAN_DEFINES_SVH
`define PRIORITY_QUEUE_LINEAR_SCAN_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, disabled while in reset.
`define PQLS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("priority queue check failed");

// Next-cycle implication, sampled on i_clk, disabled while in reset.
`define PQLS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("priority queue check failed");

`endif

[hw/rtl/pqls_pkg.sv]
// Package: types, codes and the ordering function of the priority queue.
`timescale 1ns / 1ps

package pqls_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int VAL_W         = 32;
    localparam int PRI_W         = 16;
    localparam int OCC_W         = 7;

    // Transaction action
    typedef enum logic {
        ACT_ENQ = 1'b0,
        ACT_DEQ = 1'b1
    } t_action;

    // Result status
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // One stored pair
    typedef struct packed {
        logic signed [PRI_W-1:0] pri;
        logic signed [VAL_W-1:0] val;
    } t_entry;

    // Broadcast command to every cell
    typedef struct packed {
        logic enq;
        logic deq;
    } t_cell_ctrl;

    // a is served no later than b: higher priority, then larger value
    function automatic logic entry_ge(input t_entry a, input t_entry b);
        logic pri_gt;
        logic pri_eq;
        logic val_ge;
        pri_gt = $signed(a.pri) > $signed(b.pri);
        pri_eq = a.pri == b.pri;
        val_ge = $signed(a.val) >= $signed(b.val);
        return pri_gt || (pri_eq && val_ge);
    endfunction

endpackage

[hw/rtl/pqls_cell.sv]
// One slot of the sorted chain: holds an entry, inserts or shifts with its neighbours.
`timescale 1ns / 1ps

module pqls_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pqls_pkg::t_cell_ctrl i_ctrl,
    input  pqls_pkg::t_entry    i_new,
    input  pqls_pkg::t_entry    i_left_ent,
    input  logic                i_left_vld,
    input  logic                i_left_ge,
    input  pqls_pkg::t_entry    i_right_ent,
    input  logic                i_right_vld,
    output pqls_pkg::t_entry    o_ent,
    output logic                o_vld,
    output logic                o_ge
);

    pqls_pkg::t_entry r_ent;
    pqls_pkg::t_entry n_ent;
    logic             r_vld;
    logic             n_vld;

    // Stored entry stays ahead of the incoming one
    assign o_ge  = r_vld && pqls_pkg::entry_ge(r_ent, i_new);
    assign o_ent = r_ent;
    assign o_vld = r_vld;

    // Insert: keep, take the new entry, or take the left one; remove: take the right one
    always_comb begin
        n_ent = r_ent;
        n_vld = r_vld;
        if (i_ctrl.enq) begin
            if (!o_ge) begin
                n_ent = i_left_ge ? i_new : i_left_ent;
            end
            n_vld = r_vld || i_left_vld;
        end else if (i_ctrl.deq) begin
            n_ent = i_right_ent;
            n_vld = i_right_vld;
        end
    end

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

endmodule

[hw/rtl/priority_queue_linear_scan.sv]
// Top level of the bounded priority queue.
// One transaction per clock: once an enqueue or dequeue is taken, its
// result appears in the output register on the next cycle; the input is stalled only while
// that register holds a result the consumer is stalling. Entries live in a chain of DEPTH
// cells kept sorted, best first; every cell compares its entry with the incoming one in
// parallel, so an insert or a removal is one shift of the chain and the top sits in cell 0.
// Highest priority is served first, then the larger value. Enqueue on a full queue and
// dequeue on an empty one change nothing and report a status code. Occupancy shows the
// entry count modulo 128.
`timescale 1ns / 1ps

module priority_queue_linear_scan #(
    parameter int DEPTH = pqls_pkg::DEPTH_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_action,
    input  logic signed [pqls_pkg::VAL_W-1:0] i_item_value,
    input  logic signed [pqls_pkg::PRI_W-1:0] i_item_priority,
    // Output channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [pqls_pkg::VAL_W-1:0] o_out_value,
    output logic signed [pqls_pkg::PRI_W-1:0] o_out_priority,
    output logic [1:0]                        o_status,
    output logic [pqls_pkg::OCC_W-1:0]        o_occupancy
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                 w_accept;
    logic                 w_full;
    logic                 w_empty;
    pqls_pkg::t_action    w_action;
    pqls_pkg::t_entry     w_new;
    pqls_pkg::t_cell_ctrl w_ctrl;

    pqls_pkg::t_entry     w_ent [DEPTH];
    logic                 w_vld [DEPTH];
    logic                 w_ge  [DEPTH];

    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic                 r_out_valid;
    pqls_pkg::t_entry     r_out_ent;
    pqls_pkg::t_entry     n_out_ent;
    pqls_pkg::t_status    r_status;
    pqls_pkg::t_status    n_status;

    // Handshake
    assign o_stall  = r_out_valid && i_stall;
    assign w_accept = i_valid && !o_stall;

    assign w_action  = pqls_pkg::t_action'(i_action);
    assign w_new.pri = i_item_priority;
    assign w_new.val = i_item_value;
    assign w_full    = r_count == CNT_W'(DEPTH);
    assign w_empty   = r_count == '0;

    // Command for the chain
    assign w_ctrl.enq = w_accept && (w_action == pqls_pkg::ACT_ENQ) && !w_full;
    assign w_ctrl.deq = w_accept && (w_action == pqls_pkg::ACT_DEQ) && !w_empty;

    // Chain of cells, cell 0 holds the top entry
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        pqls_pkg::t_entry w_left_ent;
        logic             w_left_vld;
        logic             w_left_ge;
        pqls_pkg::t_entry w_right_ent;
        logic             w_right_vld;

        if (g == 0) begin : g_head
            assign w_left_ent = '0;
            assign w_left_vld = 1'b1;
            assign w_left_ge  = 1'b1;
        end else begin : g_body
            assign w_left_ent = w_ent[g-1];
            assign w_left_vld = w_vld[g-1];
            assign w_left_ge  = w_ge[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right_ent = '0;
            assign w_right_vld = 1'b0;
        end else begin : g_mid
            assign w_right_ent = w_ent[g+1];
            assign w_right_vld = w_vld[g+1];
        end

        pqls_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_ctrl),
            .i_new       (w_new),
            .i_left_ent  (w_left_ent),
            .i_left_vld  (w_left_vld),
            .i_left_ge   (w_left_ge),
            .i_right_ent (w_right_ent),
            .i_right_vld (w_right_vld),
            .o_ent       (w_ent[g]),
            .o_vld       (w_vld[g]),
            .o_ge        (w_ge[g])
        );
    end

    // Next count, result and status
    always_comb begin
        n_count   = r_count;
        n_out_ent = '0;
        n_status  = pqls_pkg::ST_OK;
        if (w_ctrl.enq) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctrl.deq) begin
            n_count   = r_count - CNT_W'(1);
            n_out_ent = w_ent[0];
        end
        if (w_action == pqls_pkg::ACT_ENQ && w_full) begin
            n_status = pqls_pkg::ST_FULL;
        end else if (w_action == pqls_pkg::ACT_DEQ && w_empty) begin
            n_status = pqls_pkg::ST_EMPTY;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_ent <= n_out_ent;
            r_status  <= n_status;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_out_value    = r_out_ent.val;
    assign o_out_priority = r_out_ent.pri;
    assign o_status       = r_status;
    assign o_occupancy    = pqls_pkg::OCC_W'(r_count);

endmodule

[hw/rtl/pqls_checker.sv]
// Port-level checker for the priority queue, bound to the top level.
`timescale 1ns / 1ps
`include "priority_queue_linear_scan_defines.svh"

module pqls_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_stall,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic signed [pqls_pkg::VAL_W-1:0] o_out_value,
    input logic signed [pqls_pkg::PRI_W-1:0] o_out_priority,
    input logic [1:0]                        o_status,
    input logic [pqls_pkg::OCC_W-1:0]        o_occupancy
);

    logic w_in_acc;
    logic w_fail;
    logic w_out_held;

    assign w_in_acc   = i_valid && !o_stall;
    assign w_fail     = o_status == pqls_pkg::ST_FULL || o_status == pqls_pkg::ST_EMPTY;
    assign w_out_held = o_valid && i_stall;

    // Every accepted transaction has its result registered on the next cycle
    `PQLS_ASSERT_NXT(a_result_follows, w_in_acc, o_valid)

    // A rejected transaction returns no pair
    `PQLS_ASSERT_IMP(a_fail_zero, o_valid && w_fail, o_out_value == '0 && o_out_priority == '0)

    // An empty report leaves nothing stored
    `PQLS_ASSERT_IMP(a_empty_occ, o_valid && o_status == pqls_pkg::ST_EMPTY, o_occupancy == '0)

    // A stalled result holds
    `PQLS_ASSERT_NXT(a_stall_hold, w_out_held, o_valid && $stable(o_out_value) && $stable(o_status))

endmodule

bind priority_queue_linear_scan pqls_checker u_pqls_checker (.*);
